// File: design/rbsi_pkg.sv
// Ray-box slab intersect package: shared widths, limits and face codes.
// Depends on nothing; every other file of the block uses it.
package rbsi_pkg;

   // internal distance saturates at magnitude 2^TLIM_BITS - 1
   localparam int TLIM_BITS = 50;
   // signed distance width, wide enough for +/- 2^TLIM_BITS
   localparam int TW        = TLIM_BITS + 2;
   // magnitude width of a plane minus origin difference
   localparam int MAG_W     = 34;
   // magnitude width of a direction component
   localparam int DIR_W     = 16;
   // restoring division steps done between two pipeline registers
   localparam int DIV_STEPS = 5;
   localparam int DIST_W    = 31;

   localparam logic signed [TW-1:0] T_HIGH = TW'(1) << TLIM_BITS;
   localparam logic signed [TW-1:0] T_LOW  = -T_HIGH;
   localparam logic [TLIM_BITS-1:0] TLIM   = '1;
   localparam logic [DIST_W-1:0]    DIST_MAX = '1;

   typedef enum logic [2:0] {
      FACE_WEST  = 3'd0,
      FACE_EAST  = 3'd1,
      FACE_DOWN  = 3'd2,
      FACE_UP    = 3'd3,
      FACE_SOUTH = 3'd4,
      FACE_NORTH = 3'd5
   } face_type;

endpackage

// File: design/rbsi_if.sv
// Valid/ready channel interfaces for ray items and hit results.
// Depends on rbsi_pkg for the result widths.
interface rbsi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] box_min_x;
   logic signed [31:0] box_min_y;
   logic signed [31:0] box_min_z;
   logic [30:0]        box_size_x;
   logic [30:0]        box_size_y;
   logic [30:0]        box_size_z;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   modport source (output valid, box_min_x, box_min_y, box_min_z, box_size_x, box_size_y,
                   box_size_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, box_min_x, box_min_y, box_min_z, box_size_x, box_size_y,
                 box_size_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface rbsi_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [rbsi_pkg::DIST_W-1:0] distance;
   logic [2:0]                  face;
   logic                        face_valid;
   modport source (output valid, hit, distance, face, face_valid, input ready);
   modport sink (input valid, hit, distance, face, face_valid, output ready);
endinterface

// File: design/rbsi_div.sv
// Pipelined signed slab distance divider: t = diff * 2^DIR_FRAC_BITS / dir.
// Restoring division, DIV_STEPS quotient bits per stage; depends on rbsi_pkg.
module rbsi_div #(
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [rbsi_pkg::MAG_W-1:0]        in_mag,
   input  logic [rbsi_pkg::DIR_W-1:0]        in_dd,
   input  logic                              in_neg,
   output logic signed [rbsi_pkg::TW-1:0]    out_t
);

   localparam int QW     = rbsi_pkg::TLIM_BITS;
   localparam int STAGES = QW / rbsi_pkg::DIV_STEPS;
   localparam int DW     = rbsi_pkg::DIR_W;
   localparam int MW     = rbsi_pkg::MAG_W;

   logic [DW-1:0] rem_ff [STAGES];
   logic [QW-1:0] nb_ff  [STAGES];
   logic [QW-1:0] q_ff   [STAGES];
   logic [DW-1:0] dd_ff  [STAGES];
   logic          sat_ff [STAGES];
   logic          neg_ff [STAGES];

   logic [DW-1:0] rem_in [STAGES];
   logic [QW-1:0] nb_in  [STAGES];
   logic [QW-1:0] q_in   [STAGES];

   // split numerator: bits above the quotient range seed the remainder
   logic [MW+QW-1:0] num;
   logic [MW-1:0]    num_top;
   logic             sat0;
   always_comb begin
      num     = (MW+QW)'(in_mag) << DIR_FRAC_BITS;
      num_top = num[MW+QW-1:QW];
      sat0    = num_top >= MW'(in_dd);
   end

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         logic [DW-1:0] src_rem;
         logic [QW-1:0] src_nb;
         logic [QW-1:0] src_q;
         logic [DW-1:0] src_dd;
         logic          src_sat;
         logic          src_neg;

         // pick the stage source
         if (s == 0) begin : g_first
            assign src_rem = sat0 ? '0 : num_top[DW-1:0];
            assign src_nb  = num[QW-1:0];
            assign src_q   = '0;
            assign src_dd  = in_dd;
            assign src_sat = sat0;
            assign src_neg = in_neg;
         end else begin : g_next
            assign src_rem = rem_ff[s-1];
            assign src_nb  = nb_ff[s-1];
            assign src_q   = q_ff[s-1];
            assign src_dd  = dd_ff[s-1];
            assign src_sat = sat_ff[s-1];
            assign src_neg = neg_ff[s-1];
         end

         // run the restoring steps of this stage
         always_comb begin
            logic [DW:0]   r;
            logic [DW-1:0] rm;
            logic [QW-1:0] nb;
            logic [QW-1:0] q;
            rm = src_rem;
            nb = src_nb;
            q  = src_q;
            for (int k = 0; k < rbsi_pkg::DIV_STEPS; k++) begin
               r  = {rm, nb[QW-1]};
               nb = nb << 1;
               if (r >= {1'b0, src_dd}) begin
                  r = r - {1'b0, src_dd};
                  q = {q[QW-2:0], 1'b1};
               end else begin
                  q = {q[QW-2:0], 1'b0};
               end
               rm = r[DW-1:0];
            end
            rem_in[s] = rm;
            nb_in[s]  = nb;
            q_in[s]   = q;
         end

         // advance the stage
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in[s];
               nb_ff[s]  <= nb_in[s];
               q_ff[s]   <= q_in[s];
               dd_ff[s]  <= src_dd;
               sat_ff[s] <= src_sat;
               neg_ff[s] <= src_neg;
            end
         end
      end
   endgenerate

   // saturate and apply sign
   logic [QW-1:0] mag;
   always_comb begin
      mag   = sat_ff[STAGES-1] ? rbsi_pkg::TLIM : q_ff[STAGES-1];
      out_t = neg_ff[STAGES-1] ? -$signed(rbsi_pkg::TW'(mag)) : $signed(rbsi_pkg::TW'(mag));
   end

endmodule

// File: design/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test, fully pipelined.
// Stages: prep, 10 divider stages, slab min/max, entry/exit, result.
// Throughput: one item per cycle while the result is taken; six pipelined dividers set the depth.
// The whole pipe stalls together when the result is not taken.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
module ray_box_slab_intersect #(
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   rbsi_req_if.sink    req_ch,
   rbsi_rsp_if.source  rsp_ch
);

   localparam int TW     = rbsi_pkg::TW;
   localparam int MW     = rbsi_pkg::MAG_W;
   localparam int DW     = rbsi_pkg::DIR_W;
   localparam int STAGES = rbsi_pkg::TLIM_BITS / rbsi_pkg::DIV_STEPS;

   logic en;
   logic rsp_valid_ff;

   // advance everything when the output slot is free or taken
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // ---------------- prep: differences, magnitudes, zero axes ----------------
   logic signed [31:0] lo  [3];
   logic [30:0]        sz  [3];
   logic signed [31:0] org [3];
   logic signed [15:0] dir [3];

   always_comb begin
      lo[0] = req_ch.box_min_x;  lo[1] = req_ch.box_min_y;  lo[2] = req_ch.box_min_z;
      sz[0] = req_ch.box_size_x; sz[1] = req_ch.box_size_y; sz[2] = req_ch.box_size_z;
      org[0] = req_ch.origin_x;  org[1] = req_ch.origin_y;  org[2] = req_ch.origin_z;
      dir[0] = req_ch.dir_x;     dir[1] = req_ch.dir_y;     dir[2] = req_ch.dir_z;
   end

   logic [MW-1:0] pm_in  [6];
   logic          pneg_in[6];
   logic [DW-1:0] pdd_in [3];
   logic [2:0]    used_in;
   logic          zmiss_in;

   always_comb begin
      logic signed [32:0] hi;
      logic signed [34:0] dl;
      logic signed [34:0] dh;
      logic signed [34:0] o;
      logic [DW-1:0]      ad;
      zmiss_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         hi = 33'(lo[a]) + $signed({2'b00, sz[a]});
         o  = 35'(org[a]);
         dl = 35'(lo[a]) - o;
         dh = 35'(hi) - o;
         pm_in[2*a]     = dl[34] ? MW'(-dl) : MW'(dl);
         pm_in[2*a+1]   = dh[34] ? MW'(-dh) : MW'(dh);
         pneg_in[2*a]   = dl[34] ^ dir[a][15];
         pneg_in[2*a+1] = dh[34] ^ dir[a][15];
         ad = dir[a][15] ? DW'(-dir[a]) : DW'(dir[a]);
         used_in[a] = dir[a] != '0;
         pdd_in[a]  = used_in[a] ? ad : DW'(1);
         if (!used_in[a] && (33'(org[a]) < 33'(lo[a]) || 33'(org[a]) > hi)) begin
            zmiss_in = 1'b1;
         end
      end
   end

   logic          pv_ff;
   logic [MW-1:0] pm_ff  [6];
   logic          pneg_ff[6];
   logic [DW-1:0] pdd_ff [3];
   logic [2:0]    pused_ff;
   logic          pzmiss_ff;

   // register the prepared item
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= req_ch.valid;
      end
      if (en) begin
         pm_ff     <= pm_in;
         pneg_ff   <= pneg_in;
         pdd_ff    <= pdd_in;
         pused_ff  <= used_in;
         pzmiss_ff <= zmiss_in;
      end
   end

   // ---------------- plane distances ----------------
   logic signed [TW-1:0] t_div [6];

   genvar g;
   generate
      for (g = 0; g < 6; g++) begin : g_lane
         rbsi_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_div (
            .clock  (clock),
            .en     (en),
            .in_mag (pm_ff[g]),
            .in_dd  (pdd_ff[g/2]),
            .in_neg (pneg_ff[g]),
            .out_t  (t_div[g])
         );
      end
   endgenerate

   // carry valid and per-item flags alongside the dividers
   logic       sv_ff     [STAGES];
   logic [2:0] sused_ff  [STAGES];
   logic       szmiss_ff [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) sv_ff[s] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= pv_ff;
         for (int s = 1; s < STAGES; s++) sv_ff[s] <= sv_ff[s-1];
      end
      if (en) begin
         sused_ff[0]  <= pused_ff;
         szmiss_ff[0] <= pzmiss_ff;
         for (int s = 1; s < STAGES; s++) begin
            sused_ff[s]  <= sused_ff[s-1];
            szmiss_ff[s] <= szmiss_ff[s-1];
         end
      end
   end

   // ---------------- stage A: near/far per axis ----------------
   logic                 av_ff;
   logic signed [TW-1:0] atp_ff [6];
   logic signed [TW-1:0] an_ff  [3];
   logic signed [TW-1:0] af_ff  [3];
   logic [2:0]           aused_ff;
   logic                 azmiss_ff;
   logic signed [TW-1:0] an_in  [3];
   logic signed [TW-1:0] af_in  [3];

   always_comb begin
      logic [2:0] u;
      u = sused_ff[STAGES-1];
      for (int a = 0; a < 3; a++) begin
         if (!u[a]) begin
            an_in[a] = rbsi_pkg::T_LOW;
            af_in[a] = rbsi_pkg::T_HIGH;
         end else if (t_div[2*a] < t_div[2*a+1]) begin
            an_in[a] = t_div[2*a];
            af_in[a] = t_div[2*a+1];
         end else begin
            an_in[a] = t_div[2*a+1];
            af_in[a] = t_div[2*a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (en) begin
         av_ff <= sv_ff[STAGES-1];
      end
      if (en) begin
         atp_ff    <= t_div;
         an_ff     <= an_in;
         af_ff     <= af_in;
         aused_ff  <= sused_ff[STAGES-1];
         azmiss_ff <= szmiss_ff[STAGES-1];
      end
   end

   // ---------------- stage B: entry and exit ----------------
   logic                 bv_ff;
   logic signed [TW-1:0] btp_ff [6];
   logic signed [TW-1:0] bmin_ff;
   logic signed [TW-1:0] bmax_ff;
   logic [2:0]           bused_ff;
   logic                 bzmiss_ff;
   logic signed [TW-1:0] bmin_in;
   logic signed [TW-1:0] bmax_in;

   always_comb begin
      bmin_in = an_ff[0];
      bmax_in = af_ff[0];
      for (int a = 1; a < 3; a++) begin
         if (an_ff[a] > bmin_in) bmin_in = an_ff[a];
         if (af_ff[a] < bmax_in) bmax_in = af_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (en) begin
         bv_ff <= av_ff;
      end
      if (en) begin
         btp_ff    <= atp_ff;
         bmin_ff   <= bmin_in;
         bmax_ff   <= bmax_in;
         bused_ff  <= aused_ff;
         bzmiss_ff <= azmiss_ff;
      end
   end

   // ---------------- stage C: hit, distance, face ----------------
   logic                        hit_in;
   logic                        fv_in;
   logic [rbsi_pkg::DIST_W-1:0] dist_in;
   rbsi_pkg::face_type          face_in;
   logic                        hit_ff;
   logic                        fv_ff;
   logic [rbsi_pkg::DIST_W-1:0] dist_ff;
   rbsi_pkg::face_type          face_ff;

   always_comb begin
      logic signed [TW-1:0] t;
      logic                 found;
      rbsi_pkg::face_type   fc;
      hit_in  = 1'b0;
      fv_in   = 1'b0;
      dist_in = '0;
      face_in = rbsi_pkg::FACE_WEST;
      found   = 1'b0;
      fc      = rbsi_pkg::FACE_WEST;
      // lowest matching face wins
      for (int a = 5; a >= 0; a--) begin
         if (bused_ff[a/2] && btp_ff[a] == bmin_ff) begin
            found = 1'b1;
            fc    = rbsi_pkg::face_type'(3'(a));
         end
      end
      t = bmin_ff[TW-1] ? bmax_ff : bmin_ff;
      if (!(bzmiss_ff || bmax_ff[TW-1] || bmin_ff > bmax_ff)) begin
         hit_in = 1'b1;
         if (t[TW-1]) begin
            dist_in = '0;
         end else if (t > $signed(TW'(rbsi_pkg::DIST_MAX))) begin
            dist_in = rbsi_pkg::DIST_MAX;
         end else begin
            dist_in = t[rbsi_pkg::DIST_W-1:0];
         end
         if (!bmin_ff[TW-1] && found) begin
            fv_in   = 1'b1;
            face_in = fc;
         end
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= bv_ff;
      end
      if (en) begin
         hit_ff  <= hit_in;
         fv_ff   <= fv_in;
         dist_ff <= dist_in;
         face_ff <= face_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = hit_ff;
   assign rsp_ch.distance   = dist_ff;
   assign rsp_ch.face       = face_ff;
   assign rsp_ch.face_valid = fv_ff;

endmodule

// File: design/rbsi_checker.sv
// Port-level checks for ray_box_slab_intersect, bound to the top level.
// Depends on rbsi_pkg for widths and face codes.
module rbsi_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic [rbsi_pkg::DIST_W-1:0] rsp_distance,
   input logic [2:0]                  rsp_face,
   input logic                        rsp_face_valid
);

   // no result shows right after reset
   a_reset_clear: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped under stall");

   // a miss carries zero distance and no face
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         rsp_distance == '0 && !rsp_face_valid && rsp_face == rbsi_pkg::FACE_WEST)
      else $error("miss with payload");

   // a named face needs a hit and a legal code
   a_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_face_valid |->
         rsp_hit && (rsp_face == rbsi_pkg::FACE_WEST || rsp_face == rbsi_pkg::FACE_EAST ||
                     rsp_face == rbsi_pkg::FACE_DOWN || rsp_face == rbsi_pkg::FACE_UP ||
                     rsp_face == rbsi_pkg::FACE_SOUTH || rsp_face == rbsi_pkg::FACE_NORTH))
      else $error("bad face");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_hit        (rsp_ch.hit),
   .rsp_distance   (rsp_ch.distance),
   .rsp_face       (rsp_ch.face),
   .rsp_face_valid (rsp_ch.face_valid)
);

// File: dv/ray_box_slab_intersect_tb.sv
// Testbench for ray_box_slab_intersect: directed and random ray/box items,
// checked in order against a slab-test predictor held in a scoreboard class.
// Depends on rbsi_pkg and the rbsi_req_if / rbsi_rsp_if interfaces.
module testbench;

   localparam int FRAC      = 14;
   localparam int LIM_BITS  = 50;
   localparam int N_RANDOM  = 588;
   localparam int WATCHDOG  = 20000;

   typedef struct packed {
      logic signed [31:0] box_min_x, box_min_y, box_min_z;
      logic [30:0]        box_size_x, box_size_y, box_size_z;
      logic signed [31:0] origin_x, origin_y, origin_z;
      logic signed [15:0] dir_x, dir_y, dir_z;
   } ray_item_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] distance;
      logic [2:0]  face;
      logic        face_valid;
   } hit_item_type;

   // Slab-test predictor and the queue of expected hit results.
   class hit_scoreboard;
      hit_item_type pending[$];
      int           mismatches;

      function automatic longint plane_dist(longint diff, longint dir);
         longint ad, dd, q, r, mag;
         ad = diff < 0 ? -diff : diff;
         dd = dir < 0 ? -dir : dir;
         q = ad / dd;
         r = ad % dd;
         if ((q >> (LIM_BITS - FRAC)) != 0) begin
            mag = (64'sd1 << LIM_BITS) - 1;
         end else begin
            mag = (q << FRAC) + ((r << FRAC) / dd);
            if (mag > (64'sd1 << LIM_BITS) - 1) mag = (64'sd1 << LIM_BITS) - 1;
         end
         return ((diff < 0) != (dir < 0)) ? -mag : mag;
      endfunction

      function automatic logic [30:0] clamp31(longint t);
         if (t < 0) return '0;
         if (t > 64'sh7FFFFFFF) return '1;
         return t[30:0];
      endfunction

      function automatic hit_item_type predict_hit(ray_item_type it);
         longint lo[3], hi[3], org[3], dir[3], tp[6];
         bit     used[3];
         longint t_enter, t_exit, nr, fr;
         hit_item_type res;
         t_enter = -(64'sd1 << LIM_BITS);
         t_exit = 64'sd1 << LIM_BITS;
         res = '0;
         lo = '{longint'(it.box_min_x), longint'(it.box_min_y), longint'(it.box_min_z)};
         hi = '{lo[0] + longint'({1'b0, it.box_size_x}),
                lo[1] + longint'({1'b0, it.box_size_y}),
                lo[2] + longint'({1'b0, it.box_size_z})};
         org = '{longint'(it.origin_x), longint'(it.origin_y), longint'(it.origin_z)};
         dir = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
         for (int a = 0; a < 3; a++) begin
            if (dir[a] == 0) begin
               used[a] = 0;
               if (org[a] < lo[a] || org[a] > hi[a]) return res;
               tp[2*a] = 0;
               tp[2*a+1] = 0;
               continue;
            end
            used[a] = 1;
            tp[2*a] = plane_dist(lo[a] - org[a], dir[a]);
            tp[2*a+1] = plane_dist(hi[a] - org[a], dir[a]);
            nr = tp[2*a] < tp[2*a+1] ? tp[2*a] : tp[2*a+1];
            fr = tp[2*a] > tp[2*a+1] ? tp[2*a] : tp[2*a+1];
            if (nr > t_enter) t_enter = nr;
            if (fr < t_exit) t_exit = fr;
         end
         if (t_exit < 0 || t_enter > t_exit) return res;
         res.hit = 1;
         if (t_enter < 0) begin
            res.distance = clamp31(t_exit);
            return res;
         end
         res.distance = clamp31(t_enter);
         for (int f = 0; f < 6; f++) begin
            if (used[f >> 1] && tp[f] == t_enter) begin
               res.face = rbsi_pkg::face_type'(f);
               res.face_valid = 1;
               break;
            end
         end
         return res;
      endfunction

      function void note_ray(ray_item_type it);
         pending = {pending, predict_hit(it)};
      endfunction

      function void check_hit(hit_item_type got);
         hit_item_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected hit item %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit || got.distance !== want.distance ||
             got.face !== want.face || got.face_valid !== want.face_valid) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected hit=%0d dist=%0d face=%0d fv=%0d",
                        want.hit, want.distance, want.face, want.face_valid);
               $display("          got      hit=%0d dist=%0d face=%0d fv=%0d",
                        got.hit, got.distance, got.face, got.face_valid);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   rbsi_req_if req_ch();
   rbsi_rsp_if rsp_ch();
   hit_scoreboard board = new();

   int  send_idle_pct = 8;
   int  recv_idle_pct = 69;
   bit  recv_hold     = 0;
   int  quiet_cycles  = 0;

   ray_box_slab_intersect i_dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Receiver: random stalls, or a long hold-off while recv_hold is set.
   always @(posedge clock) begin
      if (reset || recv_hold) rsp_ch.ready <= 0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check every accepted result; watch for a stuck pipe.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_hit('{rsp_ch.hit, rsp_ch.distance, rsp_ch.face, rsp_ch.face_valid});
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || recv_hold)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("ray_box_slab_intersect verification failed");
         $finish;
      end
   end

   // Offer one item, with optional idle cycles first, and hold until taken.
   task automatic send_ray(ray_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      {req_ch.box_min_x, req_ch.box_min_y, req_ch.box_min_z,
       req_ch.box_size_x, req_ch.box_size_y, req_ch.box_size_z,
       req_ch.origin_x, req_ch.origin_y, req_ch.origin_z,
       req_ch.dir_x, req_ch.dir_y, req_ch.dir_z} <= it;
      req_ch.valid <= 1;
      do @(posedge clock); while (!req_ch.ready);
      board.note_ray(it);
   endtask

   function automatic logic signed [15:0] rand_dir();
      case ($urandom_range(9))
         0: return 16'sd0;
         1: return 16'sd16384;
         2: return -16'sd16384;
         3: return 16'sh8000;
         4: return 16'($urandom_range(3)) - 16'sd1;
         default: return 16'($urandom_range(32768)) - 16'sd16384;
      endcase
   endfunction

   // Mostly boxes near the ray, some at full range.
   function automatic ray_item_type rand_ray();
      ray_item_type it;
      bit wide;
      wide = ($urandom_range(9) == 0);
      it.dir_x = rand_dir(); it.dir_y = rand_dir(); it.dir_z = rand_dir();
      if (wide) begin
         it.box_min_x = $urandom; it.box_min_y = $urandom; it.box_min_z = $urandom;
         it.box_size_x = 31'($urandom); it.box_size_y = 31'($urandom);
         it.box_size_z = 31'($urandom);
         it.origin_x = $urandom; it.origin_y = $urandom; it.origin_z = $urandom;
      end else begin
         it.box_min_x = $signed($urandom_range(65535 << 8)) - (32768 << 8);
         it.box_min_y = $signed($urandom_range(65535 << 8)) - (32768 << 8);
         it.box_min_z = $signed($urandom_range(65535 << 8)) - (32768 << 8);
         it.box_size_x = 31'($urandom_range(1 << 22));
         it.box_size_y = 31'($urandom_range(1 << 22));
         it.box_size_z = 31'($urandom_range(1 << 22));
         it.origin_x = $signed($urandom_range(65535 << 8)) - (32768 << 8);
         it.origin_y = $signed($urandom_range(65535 << 8)) - (32768 << 8);
         it.origin_z = $signed($urandom_range(65535 << 8)) - (32768 << 8);
         // aim some rays through the box along one axis
         if ($urandom_range(2) == 0) begin
            it.origin_y = it.box_min_y + it.box_size_y / 2;
            it.origin_z = it.box_min_z + it.box_size_z / 2;
            it.dir_y = 0; it.dir_z = 0;
         end
      end
      return it;
   endfunction

   function automatic ray_item_type make_ray(int mn, int sz, int org, int dx, int dy, int dz);
      ray_item_type it;
      it.box_min_x = mn; it.box_min_y = mn; it.box_min_z = mn;
      it.box_size_x = 31'(sz); it.box_size_y = 31'(sz); it.box_size_z = 31'(sz);
      it.origin_x = org; it.origin_y = org; it.origin_z = org;
      it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
      return it;
   endfunction

   task automatic drain();
      int guard;
      guard = 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
   endtask

   initial begin
      ray_item_type it;
      req_ch.valid = 0;
      req_ch.box_min_x = 0; req_ch.box_min_y = 0; req_ch.box_min_z = 0;
      req_ch.box_size_x = 0; req_ch.box_size_y = 0; req_ch.box_size_z = 0;
      req_ch.origin_x = 0; req_ch.origin_y = 0; req_ch.origin_z = 0;
      req_ch.dir_x = 0; req_ch.dir_y = 0; req_ch.dir_z = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: each face, inside, miss, behind, zero direction, extremes
      send_ray(make_ray(4096, 4096, 0, 16384, 0, 0) );
      it = make_ray(4096, 4096, 0, 16384, 0, 0); it.origin_y = 6000; it.origin_z = 6000;
      send_ray(it);
      it.origin_x = 20000; it.dir_x = -16384; send_ray(it);
      it = make_ray(4096, 4096, 6000, 0, 16384, 0); it.origin_y = 0; send_ray(it);
      it.origin_y = 20000; it.dir_y = -16384; send_ray(it);
      it = make_ray(4096, 4096, 6000, 0, 0, 16384); it.origin_z = 0; send_ray(it);
      it.origin_z = 20000; it.dir_z = -16384; send_ray(it);
      send_ray(make_ray(4096, 4096, 0, 9459, 9459, 9459));     // corner tie
      send_ray(make_ray(4096, 4096, 6000, 16384, 0, 0));       // inside
      send_ray(make_ray(4096, 4096, 6000, 0, 0, 0));           // inside, no direction
      send_ray(make_ray(4096, 4096, 0, 0, 0, 0));              // outside, no direction
      send_ray(make_ray(4096, 4096, 20000, 16384, 16384, 0));  // box behind
      it = make_ray(4096, 4096, 0, 16384, 0, 0); it.origin_y = 99999; send_ray(it);
      send_ray(make_ray(32'h80000000, 31'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 1));
      send_ray(make_ray(32'h80000000, 31'h7FFFFFFF, 32'h80000000, -32768, -1, 1));
      send_ray(make_ray(32'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000, 1, 1, 1));
      send_ray(make_ray(32'h7FFFFFFF, 0, 32'h7FFFFFFF, -1, 16384, -32768));
      send_ray(make_ray(0, 0, 0, 16384, 16384, 16384));
      send_ray(make_ray(-5, 0, 0, 1, 1, 1));
      send_ray(make_ray(32'h55555555, 31'h2AAAAAAA, 32'hAAAAAAAA, 16'h5555, 16'h2AAA, 16'hAAAA));

      // back-pressure: hold the receiver while items keep coming
      fork
         begin
            recv_hold = 1;
            repeat (200) @(posedge clock);
            recv_hold = 0;
         end
         repeat (40) send_ray(rand_ray());
      join

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 8 : (ph == 1 ? 69 : 0);
         recv_idle_pct = ph == 0 ? 69 : (ph == 1 ? 8 : 0);
         repeat (N_RANDOM / 3) send_ray(rand_ray());
      end
      req_ch.valid <= 0;
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("ray_box_slab_intersect verification clean");
      end else begin
         $display("ray_box_slab_intersect verification failed");
      end
      $finish;
   end
endmodule
